// ===== rtl/prr_pkg.sv =====
// Shared types, constants and register codes for the PRR congestion window block.
`timescale 1ns / 1ps

package prr_pkg;

  // Widths fixed by the beat formats
  localparam int BYTE_W     = 32;
  localparam int SEG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Widest episode counter; job fields carry counters zero-extended to this
  localparam int CNT_W = 32;

  // Defaults handed to the top level
  localparam int BYTE_COUNT_WIDTH_DEF = 32;
  localparam int JOB_DEPTH_DEF        = 2;
  localparam int RESULT_DEPTH_DEF     = 2;

  // Register reset values
  localparam logic             SACK_RESET = 1'b1;
  localparam logic [SEG_W-1:0] SEG_RESET  = 16'd1448;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SACK_ENABLED = 1'b0,
    CFG_SEGMENT_SIZE = 1'b1
  } prr_cfg_idx_t;

  // Event codes
  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_ACK   = 2'd1,
    OP_SENT  = 2'd2
  } prr_op_t;

  // Input beat
  typedef struct packed {
    prr_op_t           op;
    logic [BYTE_W-1:0] unacked_bytes;
    logic [BYTE_W-1:0] sacked_bytes;
    logic [BYTE_W-1:0] delivered_bytes;
    logic              is_dup_ack;
    logic              retrans_acked;
    logic [BYTE_W-1:0] bytes_in_flight;
    logic [BYTE_W-1:0] ss_thresh;
    logic [BYTE_W-1:0] bytes_sent;
  } prr_item_t;

  // Result beat
  typedef struct packed {
    logic [BYTE_W-1:0] cwnd;
    logic              cwnd_updated;
    logic [BYTE_W-1:0] send_count;
    logic              reduction_mode;
  } prr_result_t;

  // Classified work handed from the front end to the back end
  typedef struct packed {
    logic              no_update;
    logic [CNT_W-1:0]  delivered_total;
    logic [CNT_W-1:0]  sent_total;
    logic [CNT_W-1:0]  recover_flight;
    logic [BYTE_W:0]   delivered;
    logic [BYTE_W-1:0] bytes_in_flight;
    logic [BYTE_W-1:0] ss_thresh;
    logic              safe_ack;
    logic [SEG_W-1:0]  segment_size;
  } prr_job_t;

endpackage

// ===== rtl/prr_fifo.sv =====
// Small register queue used between the stages and on the result side.
`timescale 1ns / 1ps

module prr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/prr_front.sv =====
// Front end: takes event beats, keeps the episode counters and config, emits jobs.
`timescale 1ns / 1ps

module prr_front #(
  parameter int BYTE_COUNT_WIDTH = prr_pkg::BYTE_COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  prr_pkg::prr_item_t              item,
  input  logic                            cfg_write,
  input  logic [prr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            job_push,
  input  logic                            job_full,
  output prr_pkg::prr_job_t               job
);

  import prr_pkg::*;

  localparam int W     = BYTE_COUNT_WIDTH;
  localparam int SUM_W = BYTE_W + 2;
  localparam logic [SUM_W-1:0] CNT_MAX_EXT = SUM_W'({W{1'b1}});

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_FLOOR,
    F_DELIV,
    F_TOTAL,
    F_PUSH
  } state_t;

  state_t           state;
  prr_item_t        beat;
  logic             sack_enabled;
  logic [SEG_W-1:0] segment_size;
  logic [W-1:0]     delivered_total;
  logic [W-1:0]     sent_total;
  logic [W-1:0]     recover_flight;
  logic [BYTE_W:0]  pos;
  logic [BYTE_W:0]  deliv_adj;
  logic             no_update;

  logic [SUM_W-1:0] sent_sum;
  logic [SUM_W-1:0] flight_diff;
  logic [SUM_W-1:0] flight_pos;
  logic [SUM_W-1:0] flight_size;
  logic [SUM_W-1:0] deliv_total_sum;
  logic [BYTE_W:0]  deliv_sum;
  logic             dup_ack;
  logic             add_seg;

  function automatic logic [W-1:0] sat_cnt(input logic [SUM_W-1:0] v);
    sat_cnt = (v > CNT_MAX_EXT) ? {W{1'b1}} : v[W-1:0];
  endfunction

  // Send counter update
  assign sent_sum = SUM_W'(sent_total) + SUM_W'(beat.bytes_sent);

  // Recovery flight size: SACK view floored at one segment, or the unacked bytes without SACK
  assign flight_diff = SUM_W'(pos) - SUM_W'(beat.sacked_bytes);

  always_comb begin
    if (sack_enabled) begin
      flight_pos  = (!flight_diff[SUM_W-1] && (flight_diff != '0)) ? flight_diff : '0;
      flight_size = (flight_pos < SUM_W'(segment_size)) ? SUM_W'(segment_size) : flight_pos;
    end else begin
      flight_pos  = '0;
      flight_size = SUM_W'(beat.unacked_bytes);
    end
  end

  // A duplicate ACK or an entry without SACK counts one segment while under the bound
  assign dup_ack   = (beat.op == OP_ENTER) || beat.is_dup_ack;
  assign add_seg   = dup_ack && !sack_enabled && (delivered_total < recover_flight);
  assign deliv_sum = (BYTE_W + 1)'(beat.delivered_bytes)
                   + (add_seg ? (BYTE_W + 1)'(segment_size) : '0);

  assign deliv_total_sum = SUM_W'(delivered_total) + SUM_W'(deliv_adj);

  // Job towards the back end
  assign full     = (state != F_IDLE);
  assign job_push = (state == F_PUSH);

  always_comb begin
    job.no_update       = no_update;
    job.delivered_total = CNT_W'(delivered_total);
    job.sent_total      = CNT_W'(sent_total);
    job.recover_flight  = CNT_W'(recover_flight);
    job.delivered       = deliv_adj;
    job.bytes_in_flight = beat.bytes_in_flight;
    job.ss_thresh       = beat.ss_thresh;
    job.safe_ack        = beat.retrans_acked;
    job.segment_size    = segment_size;
  end

  // Sequencer, episode state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= F_IDLE;
      sack_enabled    <= SACK_RESET;
      segment_size    <= SEG_RESET;
      delivered_total <= '0;
      sent_total      <= '0;
      recover_flight  <= W'(1);
      no_update       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SACK_ENABLED: sack_enabled <= cfg_data[0];
          CFG_SEGMENT_SIZE: segment_size <= cfg_data[SEG_W-1:0];
        endcase
      end

      unique case (state)
        F_IDLE: begin
          if (push) begin
            beat  <= item;
            state <= F_PREP;
          end
        end
        F_PREP: begin
          unique case (beat.op)
            OP_ENTER: begin
              pos             <= (BYTE_W + 1)'(beat.unacked_bytes)
                               + (BYTE_W + 1)'(beat.delivered_bytes);
              delivered_total <= '0;
              sent_total      <= '0;
              state           <= F_FLOOR;
            end
            OP_ACK: begin
              state <= F_DELIV;
            end
            OP_SENT: begin
              sent_total <= sat_cnt(sent_sum);
              no_update  <= 1'b1;
              state      <= F_PUSH;
            end
            default: begin
              no_update <= 1'b1;
              state     <= F_PUSH;
            end
          endcase
        end
        F_FLOOR: begin
          recover_flight <= sat_cnt(flight_size);
          state          <= F_DELIV;
        end
        F_DELIV: begin
          deliv_adj <= deliv_sum;
          state     <= F_TOTAL;
        end
        F_TOTAL: begin
          if (deliv_adj == '0) begin
            no_update <= 1'b1;
          end else begin
            delivered_total <= sat_cnt(deliv_total_sum);
            no_update       <= 1'b0;
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/prr_back.sv =====
// Back end: send count (proportional via bit-serial divider, or conservative) and window.
`timescale 1ns / 1ps

module prr_back #(
  parameter int BYTE_COUNT_WIDTH = prr_pkg::BYTE_COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_empty,
  output logic                 job_pop,
  input  prr_pkg::prr_job_t    job,
  output logic                 res_push,
  input  logic                 res_full,
  output prr_pkg::prr_result_t res
);

  import prr_pkg::*;

  localparam int W     = BYTE_COUNT_WIDTH;
  localparam int DVD_W = W + BYTE_W;
  localparam int SC_W  = 2 * BYTE_W;
  localparam int DCW   = $clog2(DVD_W);
  localparam logic [SC_W-1:0] BYTE_MAX = SC_W'({BYTE_W{1'b1}});

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_CEIL,
    B_SUB,
    B_LIM,
    B_ROOM,
    B_FIN,
    B_OUT
  } state_t;

  state_t            state;
  prr_job_t          j;
  logic              prop;
  logic [DVD_W-1:0]  dvd;
  logic [W-1:0]      rem;
  logic [DCW-1:0]    cnt;
  logic [SC_W-1:0]   sc_raw;
  logic [BYTE_W-1:0] room;

  logic [W-1:0]      dsr;
  logic [W:0]        rem_sh;
  logic [W:0]        rem_sub;
  logic              ge;
  logic [W-1:0]      rem_next;
  logic [SC_W-1:0]   st_ext;
  logic [CNT_W-1:0]  lim0;
  logic [BYTE_W:0]   lim1;
  logic [SC_W-1:0]   lim2;
  logic [SC_W-1:0]   flr;
  logic [SC_W-1:0]   scf;
  logic [BYTE_W-1:0] sc32;
  logic [BYTE_W:0]   cw_sum;
  logic [BYTE_W-1:0] cw;

  // Restoring divider step, one quotient bit a cycle; empty flight divides by one
  assign dsr      = (j.recover_flight[W-1:0] == '0) ? W'(1) : j.recover_flight[W-1:0];
  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign rem_next = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];

  // Conservative limit: max(delivered - sent, delivered now), plus one segment on a safe ACK
  assign st_ext = SC_W'(j.sent_total);
  assign lim0   = (j.delivered_total > j.sent_total) ? (j.delivered_total - j.sent_total) : '0;
  assign lim1   = ((BYTE_W + 1)'(lim0) < j.delivered) ? j.delivered : (BYTE_W + 1)'(lim0);
  assign lim2   = sc_raw + (j.safe_ack ? SC_W'(j.segment_size) : '0);

  // First-send floor, saturation and window
  assign flr    = (j.sent_total == '0) ? SC_W'(j.segment_size) : '0;
  assign scf    = (sc_raw < flr) ? flr : sc_raw;
  assign sc32   = (scf > BYTE_MAX) ? {BYTE_W{1'b1}} : scf[BYTE_W-1:0];
  assign cw_sum = (BYTE_W + 1)'(j.bytes_in_flight) + (BYTE_W + 1)'(sc32);
  assign cw     = cw_sum[BYTE_W] ? {BYTE_W{1'b1}} : cw_sum[BYTE_W-1:0];

  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign res_push = (state == B_OUT);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            j    <= job;
            prop <= (job.bytes_in_flight > job.ss_thresh);
            if (job.no_update) begin
              res   <= '0;
              state <= B_OUT;
            end else if (job.bytes_in_flight > job.ss_thresh) begin
              state <= B_MUL;
            end else begin
              state <= B_LIM;
            end
          end
        end
        B_MUL: begin
          dvd   <= DVD_W'(j.delivered_total[W-1:0]) * DVD_W'(j.ss_thresh);
          rem   <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          dvd <= {dvd[DVD_W-2:0], ge};
          rem <= rem_next;
          cnt <= cnt + DCW'(1);
          if (cnt == DCW'(DVD_W - 1)) begin
            state <= B_CEIL;
          end
        end
        B_CEIL: begin
          // round up on a non-zero remainder
          sc_raw <= SC_W'(dvd) + SC_W'(rem != '0);
          state  <= B_SUB;
        end
        B_SUB: begin
          sc_raw <= (sc_raw > st_ext) ? (sc_raw - st_ext) : '0;
          state  <= B_FIN;
        end
        B_LIM: begin
          sc_raw <= SC_W'(lim1);
          room   <= j.ss_thresh - j.bytes_in_flight;
          state  <= B_ROOM;
        end
        B_ROOM: begin
          sc_raw <= (lim2 < SC_W'(room)) ? lim2 : SC_W'(room);
          state  <= B_FIN;
        end
        B_FIN: begin
          res.cwnd           <= cw;
          res.cwnd_updated   <= 1'b1;
          res.send_count     <= sc32;
          res.reduction_mode <= !prop;
          state              <= B_OUT;
        end
        B_OUT: begin
          if (!res_full) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/prr_congestion_window.sv =====
// Top level of the PRR congestion window block: front end, job queue, back end, result queue.
//
//   channel  | ports                           | beat taken when
//   ---------+---------------------------------+----------------------------
//   event    | push, full, item                | push && !full
//   result   | empty, pop, result              | pop && !empty
//   config   | cfg_write, cfg_index, cfg_data  | cfg_write
//
// The front end takes one event beat at a time.
// A proportional-branch ACK holds the back end while the bit-serial divider runs
// (one quotient bit a cycle); other beats skip the divider.
// A job queue of JOB_DEPTH entries (two by default) lets the front end classify the next beat meanwhile.
// Reset is synchronous; both queues empty, counters clear, recovery flight is one.
// Results wait in the result queue while pop is low; once both queues fill, the front end holds full high.
`timescale 1ns / 1ps

module prr_congestion_window #(
  parameter int BYTE_COUNT_WIDTH = prr_pkg::BYTE_COUNT_WIDTH_DEF,
  parameter int JOB_DEPTH        = prr_pkg::JOB_DEPTH_DEF,
  parameter int RESULT_DEPTH     = prr_pkg::RESULT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  prr_pkg::prr_item_t             item,
  output logic                           empty,
  input  logic                           pop,
  output prr_pkg::prr_result_t           result,
  input  logic                           cfg_write,
  input  logic [prr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0] cfg_data
);

  import prr_pkg::*;

  prr_job_t    job_wr;
  prr_job_t    job_rd;
  logic        job_push;
  logic        job_full;
  logic        job_pop;
  logic        job_empty;
  prr_result_t res_wr;
  logic        res_push;
  logic        res_full;

  // Classification and episode state
  prr_front #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_wr)
  );

  // Decoupling queue
  prr_fifo #(
    .WIDTH($bits(prr_job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data(job_wr),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_data(job_rd),
    .empty  (job_empty)
  );

  // Send count and window
  prr_back #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .job      (job_rd),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res_wr)
  );

  // Result queue
  prr_fifo #(
    .WIDTH($bits(prr_result_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_wr),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule

// ===== rtl/prr_checker.sv =====
// Port-level checks for the PRR congestion window block, bound to the top level.
`timescale 1ns / 1ps

module prr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input prr_pkg::prr_result_t result
);

  // Out of reset the block is ready and holds no result
  a_reset_idle: assert property (@(posedge clk) !rst && $past(rst) |-> !full && empty)
    else $error("not idle after reset");

  // An accepted event keeps the front end busy through the prepare state and the state that follows it
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full ##1 full)
    else $error("front end free too soon after a beat");

  // The front end only goes busy on an accepted beat
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !full && !push |=> !full)
    else $error("full rose without a beat");

  // A waiting result stays put until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

endmodule

bind prr_congestion_window prr_checker u_prr_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);
